FILE: rtl/quaternion_to_euler_degrees_defines.svh
// Assertion macros shared by the quaternion to Euler angle converter.
`ifndef QUATERNION_TO_EULER_DEGREES_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define QTE_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define QTE_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/qte_pkg.sv
// Types, constants and CORDIC helper functions of the quaternion to Euler converter.
package qte_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int DEG_FRAC       = 16;
    localparam int SQRT_STEPS     = 31;
    localparam int DW             = 40;
    localparam int ZW             = 26;
    localparam int UW             = 17;
    localparam int ROLL_LIM       = 23040;
    localparam int PITCH_LIM      = 11520;
    localparam int Q_SHR          = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
    localparam int Q_SHL          = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;

    typedef logic signed [DW-1:0] dat_t;
    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [UW-1:0] unit_t;

    typedef struct packed {
        dat_t x;
        dat_t y;
        ang_t z;
        logic zero;
    } cordic_t;

    typedef struct packed {
        dat_t              rn;
        dat_t              rd;
        dat_t              yn;
        dat_t              yd;
        logic signed [31:0] s30;
        logic              clamp;
    } pay_t;

    function automatic ang_t atan_deg(input int i);
        ang_t r;
        unique case (i)
            0:       r = ang_t'(2949120);
            1:       r = ang_t'(1740967);
            2:       r = ang_t'(919879);
            3:       r = ang_t'(466945);
            4:       r = ang_t'(234379);
            5:       r = ang_t'(117304);
            6:       r = ang_t'(58666);
            7:       r = ang_t'(29335);
            8:       r = ang_t'(14668);
            9:       r = ang_t'(7334);
            10:      r = ang_t'(3667);
            11:      r = ang_t'(1833);
            12:      r = ang_t'(917);
            13:      r = ang_t'(458);
            14:      r = ang_t'(229);
            15:      r = ang_t'(115);
            16:      r = ang_t'(57);
            17:      r = ang_t'(29);
            18:      r = ang_t'(14);
            19:      r = ang_t'(7);
            20:      r = ang_t'(4);
            21:      r = ang_t'(2);
            22:      r = ang_t'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic dat_t to_q30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v >>> Q_SHR) <<< Q_SHL;
        return t[DW-1:0];
    endfunction

    function automatic cordic_t cordic_init(input dat_t y, input dat_t x);
        cordic_t c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = ang_t'(90 <<< DEG_FRAC);
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -ang_t'(90 <<< DEG_FRAC);
            end
        end
        return c;
    endfunction

    function automatic cordic_t cordic_rot(input cordic_t c, input int i);
        cordic_t r;
        dat_t    dx;
        dat_t    dy;
        dx     = c.x >>> i;
        dy     = c.y >>> i;
        r.zero = c.zero;
        if (c.y >= 0) begin
            r.x = c.x + dy;
            r.y = c.y - dx;
            r.z = c.z + atan_deg(i);
        end else begin
            r.x = c.x - dy;
            r.y = c.y + dx;
            r.z = c.z - atan_deg(i);
        end
        return r;
    endfunction

    function automatic unit_t to_units(input cordic_t c, input int lim);
        logic signed [ZW:0] s;
        unit_t              r;
        s = ((ZW+1)'(c.z) + (ZW+1)'(256)) >>> (DEG_FRAC - 7);
        r = s[UW-1:0];
        if (c.zero) begin
            r = '0;
        end else if (r > unit_t'(lim)) begin
            r = unit_t'(lim);
        end else if (r < -unit_t'(lim)) begin
            r = -unit_t'(lim);
        end
        return r;
    endfunction

endpackage

FILE: rtl/quaternion_to_euler_degrees.sv
// Pipelined converter from an attitude quaternion to roll, pitch and yaw in degrees.
// One quaternion may enter every cycle unless in_stall is high, and each gives one result
// after passing, in order, the products, sums, the square of the pitch sine, the radicand,
// 31 one-bit square root stages, the CORDIC quadrant stage, the CORDIC stages and the
// output register. The whole pipe holds while a finished result is stalled at the output.
`include "quaternion_to_euler_degrees_defines.svh"

module quaternion_to_euler_degrees (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  roll_angle,
    output logic signed [14:0]  pitch_angle,
    output logic signed [15:0]  yaw_angle,
    output logic                pitch_clamped
);
    import qte_pkg::*;

    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< (2 * QUAT_FRAC_BITS);

    logic adv;

    logic               v1_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;

    logic               v2_reg;
    pay_t               p2_reg;
    pay_t               p2_next;
    logic signed [63:0] rn64, rd64, yn64, yd64, s64;

    logic               v3_reg;
    pay_t               p3_reg;
    logic [60:0]        sq_reg;
    logic signed [63:0] sq_full;

    logic               sv_reg   [0:SQRT_STEPS];
    pay_t               sp_reg   [0:SQRT_STEPS];
    logic [61:0]        rem_reg  [0:SQRT_STEPS];
    logic [61:0]        root_reg [0:SQRT_STEPS];

    logic               cv_reg   [0:CORDIC_STAGES];
    cordic_t            cr_reg   [0:CORDIC_STAGES];
    cordic_t            cp_reg   [0:CORDIC_STAGES];
    cordic_t            cy_reg   [0:CORDIC_STAGES];
    logic               cc_reg   [0:CORDIC_STAGES];

    logic               out_valid_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               clamp_reg;
    unit_t              roll_u, pitch_u, yaw_u;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            sv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
        end
    end

    always_comb begin
        rn64 = (64'(wx_reg) + 64'(yz_reg)) <<< 1;
        rd64 = ONE_Q - ((64'(xx_reg) + 64'(yy_reg)) <<< 1);
        yn64 = (64'(wz_reg) + 64'(xy_reg)) <<< 1;
        yd64 = ONE_Q - ((64'(yy_reg) + 64'(zz_reg)) <<< 1);
        s64  = (64'(wy_reg) - 64'(zx_reg)) <<< 1;
        p2_next.clamp = 1'b0;
        if (s64 > ONE_Q) begin
            s64 = ONE_Q;
            p2_next.clamp = 1'b1;
        end else if (s64 < -ONE_Q) begin
            s64 = -ONE_Q;
            p2_next.clamp = 1'b1;
        end
        p2_next.rn  = to_q30(rn64);
        p2_next.rd  = to_q30(rd64);
        p2_next.yn  = to_q30(yn64);
        p2_next.yd  = to_q30(yd64);
        p2_next.s30 = 32'(to_q30(s64));
    end

    assign sq_full = p2_reg.s30 * p2_reg.s30;

    always_ff @(posedge clk) begin
        if (adv) begin
            p2_reg      <= p2_next;
            p3_reg      <= p2_reg;
            sq_reg      <= sq_full[60:0];
            sp_reg[0]   <= p3_reg;
            rem_reg[0]  <= {1'b0, 61'(62'(1) << 60) - sq_reg};
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [61:0] SB = 62'(1) << (60 - 2 * k);
        logic [61:0] trial;

        assign trial = root_reg[k] + SB;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                sv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                sp_reg[k+1] <= sp_reg[k];
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + SB;
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cv_reg[0] <= 1'b0;
        end else if (adv) begin
            cv_reg[0] <= sv_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            cr_reg[0] <= cordic_init(sp_reg[SQRT_STEPS].rn, sp_reg[SQRT_STEPS].rd);
            cy_reg[0] <= cordic_init(sp_reg[SQRT_STEPS].yn, sp_reg[SQRT_STEPS].yd);
            cp_reg[0] <= cordic_init(dat_t'(sp_reg[SQRT_STEPS].s30),
                                     dat_t'({1'b0, root_reg[SQRT_STEPS][30:0]}));
            cc_reg[0] <= sp_reg[SQRT_STEPS].clamp;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                cv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                cr_reg[i+1] <= cordic_rot(cr_reg[i], i);
                cy_reg[i+1] <= cordic_rot(cy_reg[i], i);
                cp_reg[i+1] <= cordic_rot(cp_reg[i], i);
                cc_reg[i+1] <= cc_reg[i];
            end
        end
    end

    assign roll_u  = to_units(cr_reg[CORDIC_STAGES], ROLL_LIM);
    assign pitch_u = to_units(cp_reg[CORDIC_STAGES], PITCH_LIM);
    assign yaw_u   = to_units(cy_reg[CORDIC_STAGES], ROLL_LIM);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= cv_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            roll_reg  <= roll_u[15:0];
            pitch_reg <= pitch_u[14:0];
            yaw_reg   <= yaw_u[15:0];
            clamp_reg <= cc_reg[CORDIC_STAGES];
        end
    end

    assign out_valid     = out_valid_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamp_reg;

    `QTE_ASSERT_NOW(a_roll_range, out_valid, (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040), "roll out of range")
    `QTE_ASSERT_NOW(a_yaw_range, out_valid, (yaw_angle <= 16'sd23040) && (yaw_angle >= -16'sd23040), "yaw out of range")
    `QTE_ASSERT_NOW(a_pitch_range, out_valid, (pitch_angle <= 15'sd11520) && (pitch_angle >= -15'sd11520), "pitch out of range")
    `QTE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid_reg && $stable(cv_reg[0]), "pipeline moved during stall")

endmodule

FILE: verif/quaternion_to_euler_degrees_tb.sv
// Self-checking testbench of the quaternion to Euler angle converter.
`timescale 1ns / 1ps

module quaternion_to_euler_degrees_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    localparam int FRAC = 14;
    localparam int STAGES = 16;
    localparam int LATENCY = 53;
    localparam longint DEG90 = longint'(90) <<< 16;

    angles_t angles_due[$];
    int      errors;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;

    quaternion_to_euler_degrees dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint scale_q30(longint v);
        if (2 * FRAC >= 30)
            return floor_shr(v, 2 * FRAC - 30);
        return v <<< (30 - 2 * FRAC);
    endfunction

    function automatic longint stage_angle(int i);
        longint angs[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return angs[i];
    endfunction

    function automatic longint vector_angle(longint ny, longint nx);
        longint a;
        longint px;
        longint py;
        longint t;
        a = 0;
        if (nx == 0 && ny == 0)
            return 0;
        if (nx < 0)
        begin
            t = nx;
            if (ny >= 0)
            begin
                nx = ny;
                ny = -t;
                a = DEG90;
            end
            else
            begin
                nx = -ny;
                ny = t;
                a = -DEG90;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            px = nx;
            py = ny;
            if (py >= 0)
            begin
                nx = px + floor_shr(py, i);
                ny = py - floor_shr(px, i);
                a += stage_angle(i);
            end
            else
            begin
                nx = px - floor_shr(py, i);
                ny = py + floor_shr(px, i);
                a -= stage_angle(i);
            end
        end
        return a;
    endfunction

    function automatic longint deg_units(longint a, longint lim);
        longint r;
        r = floor_shr(a + 256, 9);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
        angles_t e;
        longint one;
        longint s;
        longint s30;
        longint c;
        one = longint'(1) <<< (2 * FRAC);
        s = 2 * (w * y - z * x);
        e.clamped = 1'b0;
        if (s > one)
        begin
            s = one;
            e.clamped = 1'b1;
        end
        if (s < -one)
        begin
            s = -one;
            e.clamped = 1'b1;
        end
        e.roll = 16'(deg_units(vector_angle(scale_q30(2 * (w * x + y * z)),
            scale_q30(one - 2 * (x * x + y * y))), 23040));
        e.yaw = 16'(deg_units(vector_angle(scale_q30(2 * (w * z + x * y)),
            scale_q30(one - 2 * (y * y + z * z))), 23040));
        s30 = scale_q30(s);
        c = root_floor((64'd1 << 60) - longint'(s30 * s30));
        e.pitch = 15'(deg_units(vector_angle(s30, c), 11520));
        return e;
    endfunction

    task automatic send_quat(int w, int x, int y, int z);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= 16'(w);
        quat_x <= 16'(x);
        quat_y <= 16'(y);
        quat_z <= 16'(z);
        angles_due.push_back(euler_of($signed(16'(w)), $signed(16'(x)),
            $signed(16'(y)), $signed(16'(z))));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (angles_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic int rand_comp();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    task automatic send_unit_quat();
        real a;
        real b;
        real c;
        real d;
        real n;
        a = real'(rand_comp());
        b = real'(rand_comp());
        c = real'(rand_comp());
        d = real'(rand_comp());
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            n = 1.0;
        send_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
            int'(c * 16384.0 / n), int'(d * 16384.0 / n));
    endtask

    task automatic test_directed();
        int ext[5] = '{-16384, -1, 0, 1, 16384};
        send_quat(16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);
        send_quat(-16384, 0, 16384, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-1, -1, -1, -1);
        for (int i = 0; i < 5; i++)
            send_quat(ext[i], ext[4 - i], ext[(i + 2) % 5], ext[(i + 3) % 5]);
        send_quat(0, 11585, 0, 11585);
        send_quat(0, 0, 16384, 0);
        drain();
    endtask

    task automatic test_random(int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(9);
            if (k < 6)
                send_unit_quat();
            else if (k < 8)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            else
                send_quat($urandom, $urandom, $urandom, $urandom);
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 150;
        for (int i = 0; i < 80; i++)
            send_unit_quat();
        drain();
    endtask

    always @(posedge clk)
    begin
        angles_t exp_e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (angles_due.size() == 0)
            begin
                $display("%0t: unexpected result roll %0d pitch %0d yaw %0d", $time,
                    roll_angle, pitch_angle, yaw_angle);
                errors++;
            end
            else
            begin
                exp_e = angles_due.pop_front();
                if (roll_angle !== exp_e.roll)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll,
                        roll_angle);
                    errors++;
                end
                if (pitch_angle !== exp_e.pitch)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch,
                        pitch_angle);
                    errors++;
                end
                if (yaw_angle !== exp_e.yaw)
                begin
                    $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw,
                        yaw_angle);
                    errors++;
                end
                if (pitch_clamped !== exp_e.clamped)
                begin
                    $display("%0t: clamp expected %0d actual %0d", $time, exp_e.clamped,
                        pitch_clamped);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        #10000000;
        $display("FAIL quaternion_to_euler_degrees");
        $finish;
    end

    initial
    begin
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_idle_pct = 27;
        recv_idle_pct = 65;
        test_directed();
        test_random(130);
        send_idle_pct = 65;
        recv_idle_pct = 27;
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90);
        test_backpressure();
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && angles_due.size() == 0)
            $display("PASS quaternion_to_euler_degrees");
        else
            $display("FAIL quaternion_to_euler_degrees");
        $finish;
    end

endmodule
